FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL. Every check is sampled on clk_i and
// held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define PSH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PSH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/psh_pkg.sv
package psh_pkg;

  // Modulus and its small multiples, used by the range folds
  localparam logic [31:0] HashMod  = 32'd1000000009;
  localparam logic [31:0] HashMod2 = 32'd2000000018;
  localparam logic [31:0] HashMod3 = 32'd3000000027;

  // floor(2^46 / HashMod), quotient estimate for a 46-bit product
  localparam logic [16:0] RecipMu = 17'd70368;

  // Power of the base at the start of a string
  localparam logic [29:0] PowerInit = 30'd1;

  // One character on its way into the multiply-reduce pipeline
  typedef struct packed {
    logic [15:0] char_code;
    logic [29:0] power;
    logic        last;
  } chr_t;

  // Reduced term char * power mod M, ready for accumulation
  typedef struct packed {
    logic [29:0] term;
    logic        last;
  } term_t;

  // Reduce a value below 4M into 0 .. M-1
  function automatic logic [29:0] mod_fold(input logic [31:0] r);
    logic [31:0] res;
    priority if (r >= HashMod3) begin
      res = r - HashMod3;
    end else if (r >= HashMod2) begin
      res = r - HashMod2;
    end else if (r >= HashMod) begin
      res = r - HashMod;
    end else begin
      res = r;
    end
    return res[29:0];
  endfunction

  // power * 31 mod M; the top five bits give a quotient estimate that is
  // at most three short, so the remainder stays below 4M
  function automatic logic [29:0] power_step(input logic [29:0] pow);
    logic [34:0] x;
    logic [34:0] qm;
    x  = (35'(pow) << 5) - 35'(pow);
    qm = 35'(x[34:30]) * 35'(HashMod);
    return mod_fold(32'(x - qm));
  endfunction

endpackage

FILE: rtl/psh_power.sv
module psh_power (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [15:0]      char_code_i,
  input  logic             has_char_i,
  input  logic             last_i,
  output psh_pkg::chr_t    chr_o,
  output logic             chr_valid_o,
  input  logic             chr_ready_i,
  output logic [29:0]      power_o
);

  logic [29:0]   power_q, power_d;
  logic          valid_q;
  psh_pkg::chr_t chr_q;
  logic          accept;

  assign in_ready_o = !valid_q || chr_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Power advances only on a character and restarts after the last item
  always_comb begin
    power_d = power_q;
    if (accept) begin
      if (last_i) begin
        power_d = psh_pkg::PowerInit;
      end else if (has_char_i) begin
        power_d = psh_pkg::power_step(power_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= psh_pkg::PowerInit;
      valid_q <= 1'b0;
    end else begin
      power_q <= power_d;
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  // Input register; an item without a character carries a zero code so
  // its term is zero and the hash is left as it is
  always_ff @(posedge clk_i) begin
    if (accept) begin
      chr_q.char_code <= has_char_i ? char_code_i : 16'd0;
      chr_q.power     <= power_q;
      chr_q.last      <= last_i;
    end
  end

  assign chr_o       = chr_q;
  assign chr_valid_o = valid_q;
  assign power_o     = power_q;

endmodule

FILE: rtl/psh_modmul.sv
module psh_modmul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psh_pkg::chr_t  chr_i,
  input  logic           chr_valid_i,
  output logic           chr_ready_o,
  output psh_pkg::term_t term_o,
  output logic           term_valid_o,
  input  logic           term_ready_i
);

  // Stage valids and backpressure, bubbles collapse
  logic va_q, vb_q, vc_q, vd_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  logic [45:0] pa_q;
  logic        la_q;
  logic [16:0] qb_q;
  logic [31:0] plb_q;
  logic        lb_q;
  logic [31:0] rc_q;
  logic        lc_q;
  logic [29:0] td_q;
  logic        ld_q;

  logic [33:0] qest;
  logic [46:0] qm;

  assign rdy_d = !vd_q || term_ready_i;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign chr_ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= chr_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  // Quotient estimate from the top 17 bits of the product, at most two short
  assign qest = 34'(pa_q[45:29]) * 34'(psh_pkg::RecipMu);
  // Remainder is below 3M, so the low 32 bits are enough
  assign qm   = 47'(qb_q) * 47'(psh_pkg::HashMod);

  always_ff @(posedge clk_i) begin
    // Stage A: char * power
    if (rdy_a && chr_valid_i) begin
      pa_q <= 46'(chr_i.char_code) * 46'(chr_i.power);
      la_q <= chr_i.last;
    end
    // Stage B: quotient estimate
    if (rdy_b && va_q) begin
      qb_q  <= qest[33:17];
      plb_q <= pa_q[31:0];
      lb_q  <= la_q;
    end
    // Stage C: rough remainder
    if (rdy_c && vb_q) begin
      rc_q <= plb_q - qm[31:0];
      lc_q <= lb_q;
    end
    // Stage D: final fold into 0 .. M-1
    if (rdy_d && vc_q) begin
      td_q <= psh_pkg::mod_fold(rc_q);
      ld_q <= lc_q;
    end
  end

  assign term_o.term  = td_q;
  assign term_o.last  = ld_q;
  assign term_valid_o = vd_q;

endmodule

FILE: rtl/psh_accum.sv
module psh_accum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psh_pkg::term_t term_i,
  input  logic           term_valid_i,
  output logic           term_ready_o,
  output logic [29:0]    hash_o,
  output logic           hash_valid_o,
  input  logic           hash_ready_i
);

  logic [29:0] hash_q, hash_d;
  logic        out_valid_q, out_valid_d;
  logic [29:0] out_hash_q;
  logic [30:0] sum;
  logic [30:0] sum_red;
  logic        take;

  // Only a last item needs room in the result register
  assign term_ready_o = !term_i.last || !out_valid_q || hash_ready_i;
  assign take         = term_valid_i && term_ready_o;

  // hash + term, both below M, one conditional subtract
  always_comb begin
    sum = 31'(hash_q) + 31'(term_i.term);
    if (sum >= 31'(psh_pkg::HashMod)) begin
      sum_red = sum - 31'(psh_pkg::HashMod);
    end else begin
      sum_red = sum;
    end
  end

  always_comb begin
    hash_d      = hash_q;
    out_valid_d = out_valid_q && !hash_ready_i;
    if (take) begin
      if (term_i.last) begin
        hash_d      = 30'd0;
        out_valid_d = 1'b1;
      end else begin
        hash_d = sum_red[29:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= 30'd0;
      out_valid_q <= 1'b0;
    end else begin
      hash_q      <= hash_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (take && term_i.last) begin
      out_hash_q <= sum_red[29:0];
    end
  end

  assign hash_o       = out_hash_q;
  assign hash_valid_o = out_valid_q;

endmodule

FILE: rtl/polynomial_string_hash.sv
// Polynomial string hash modulo 1000000009: each character c adds c * 31^i
// (i counting the characters of the string) to a running hash, and the item
// flagged tlast returns the finished hash, below 1000000009, then restarts
// at hash 0 and power 1. An item whose tuser flag is low carries no
// character, so a lone such item with tlast hashes an empty string to 0.
// One item is taken every cycle unless a waiting result holds the pipeline;
// a result passes the input register, the pipeline stages and the result
// register before it is offered. The rate is set by two loops, the power of
// 31 update at the input and the add-and-subtract hash accumulator at the
// output, with the char * power product reduced in a four-stage pipeline
// between them. Items that give no result keep flowing while a result waits
// to be taken, until the next last item reaches the accumulator.
`include "assert_macros.svh"

module polynomial_string_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] char_code
  input  logic        s_axis_tuser,   // [0] has_char
  input  logic        s_axis_tlast,   // last_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [29:0] hash, [31:30] zero
);

  psh_pkg::chr_t  chr;
  logic           chr_valid, chr_ready;
  psh_pkg::term_t term;
  logic           term_valid, term_ready;
  logic [29:0]    power;
  logic [29:0]    hash;

  // Input register and power of the base
  psh_power u_power (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .char_code_i (s_axis_tdata),
    .has_char_i  (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .chr_o       (chr),
    .chr_valid_o (chr_valid),
    .chr_ready_i (chr_ready),
    .power_o     (power)
  );

  // char * power mod M
  psh_modmul u_modmul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chr_i        (chr),
    .chr_valid_i  (chr_valid),
    .chr_ready_o  (chr_ready),
    .term_o       (term),
    .term_valid_o (term_valid),
    .term_ready_i (term_ready)
  );

  // Running hash and result register
  psh_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_i       (term),
    .term_valid_i (term_valid),
    .term_ready_o (term_ready),
    .hash_o       (hash),
    .hash_valid_o (m_axis_tvalid),
    .hash_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, hash};

  // Checks
  `PSH_ASSERT_NXT(a_power_restart, s_axis_tvalid && s_axis_tready && s_axis_tlast, power == psh_pkg::PowerInit, "power not restarted after last item")
  `PSH_ASSERT_NXT(a_power_hold, s_axis_tvalid && s_axis_tready && !s_axis_tuser && !s_axis_tlast, power == $past(power), "power moved on an item without a character")
  `PSH_ASSERT_IMP(a_power_range, 1'b1, power != 30'd0 && 32'(power) < psh_pkg::HashMod, "power out of range")
  `PSH_ASSERT_IMP(a_hash_range, m_axis_tvalid, m_axis_tdata < psh_pkg::HashMod, "hash result out of range")

endmodule

FILE: tb/tb_top.sv
module tb_top;

  // Modulus and base of the string hash
  localparam logic [63:0] HASH_M    = 64'd1000000009;
  localparam logic [63:0] HASH_BASE = 64'd31;

  localparam int DIR_ROWS  = 21;
  localparam int RAND_ITEMS = 1800;
  localparam int MAX_SHOWN  = 10;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] char_code
  logic        s_axis_tuser = 1'b0; // [0] has_char
  logic        s_axis_tlast = 1'b0; // last_of_string
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [29:0] hash, [31:30] zero

  polynomial_string_hash uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // One directed row: item fields, plus a hash typed in where it is obvious
  typedef struct packed {
    logic [15:0] code;
    logic        has;
    logic        last;
    logic        known;
    logic [29:0] hash;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{16'h0000, 1'b0, 1'b1, 1'b1, 30'd0},     // empty string
    '{16'hFFFF, 1'b1, 1'b1, 1'b1, 30'd65535}, // largest code, one char
    '{16'h0000, 1'b1, 1'b1, 1'b1, 30'd0},     // zero code, one char
    '{16'h0001, 1'b1, 1'b0, 1'b0, 30'd0},
    '{16'h0001, 1'b1, 1'b1, 1'b1, 30'd32},    // 1 + 1*31
    '{16'hFFFF, 1'b0, 1'b0, 1'b0, 30'd0},     // no char, code ignored
    '{16'h0005, 1'b1, 1'b1, 1'b1, 30'd5},     // power untouched by the gap
    '{16'hAAAA, 1'b0, 1'b1, 1'b1, 30'd0},     // empty string, junk code
    '{16'h5555, 1'b1, 1'b0, 1'b0, 30'd0},
    '{16'hAAAA, 1'b0, 1'b0, 1'b0, 30'd0},
    '{16'h0002, 1'b1, 1'b1, 1'b0, 30'd0},
    '{16'hFFFF, 1'b1, 1'b0, 1'b0, 30'd0},     // run of largest codes
    '{16'hFFFF, 1'b1, 1'b0, 1'b0, 30'd0},
    '{16'hFFFF, 1'b1, 1'b0, 1'b0, 30'd0},
    '{16'hFFFF, 1'b1, 1'b0, 1'b0, 30'd0},
    '{16'hFFFF, 1'b1, 1'b0, 1'b0, 30'd0},
    '{16'hFFFF, 1'b1, 1'b0, 1'b0, 30'd0},
    '{16'hFFFF, 1'b1, 1'b0, 1'b0, 30'd0},
    '{16'hFFFF, 1'b1, 1'b0, 1'b0, 30'd0},
    '{16'hFFFF, 1'b0, 1'b0, 1'b0, 30'd0},
    '{16'hFFFF, 1'b1, 1'b1, 1'b0, 30'd0}
  };

  // Running hash state and the queue of hashes still owed by the block
  logic [29:0] hash_acc  = '0;
  logic [29:0] power_acc = 30'd1;
  logic [29:0] owed_hashes [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent;
  int strings_sent;
  int hashes_seen;
  int mismatches;
  logic [29:0] owed;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Fold one accepted item into the hash; returns 1 with the hash on tlast
  function automatic logic fold_item(input logic [15:0] code, input logic has,
                                     input logic last, output logic [29:0] hash);
    logic [63:0] sum;
    sum  = 64'(hash_acc) + 64'(code) * 64'(power_acc);
    hash = hash_acc;
    if (has) begin
      hash_acc  = 30'(sum % HASH_M);
      power_acc = 30'((64'(power_acc) * HASH_BASE) % HASH_M);
    end
    if (!last) return 1'b0;
    hash      = hash_acc;
    hash_acc  = '0;
    power_acc = 30'd1;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, act_v);
  endtask

  // Offer one item, with random idle cycles ahead of it; called at a falling edge
  task automatic send_item(input logic [15:0] code, input logic has, input logic last,
                           input logic known, input logic [29:0] known_hash);
    logic [29:0] hash;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tuser  <= has;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (fold_item(code, has, last, hash)) begin
      owed_hashes.push_back(known ? known_hash : hash);
      strings_sent++;
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // A string of random length and content; a few are long to reach high powers
  task automatic send_string();
    int len;
    logic [15:0] code;
    len = ($urandom_range(9) == 0) ? int'($urandom_range(200, 30))
                                   : int'($urandom_range(12));
    if (len == 0) begin
      send_item(16'($urandom), 1'b0, 1'b1, 1'b0, '0);
      return;
    end
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(7))
        0:       code = 16'h0000;
        1:       code = 16'hFFFF;
        default: code = 16'($urandom);
      endcase
      send_item(code, $urandom_range(9) != 0, i == len - 1, 1'b0, '0);
    end
  endtask

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted hash with the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      hashes_seen++;
      if (owed_hashes.size() == 0) begin
        note_mismatch("hash with none owed", 32'd0, m_axis_tdata);
      end else begin
        owed = owed_hashes.pop_front();
        if (m_axis_tdata !== {2'b00, owed})
          note_mismatch("hash", {2'b00, owed}, m_axis_tdata);
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout with %0d hashes still owed", owed_hashes.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int target;
    int waited;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows, no idling
    for (int r = 0; r < DIR_ROWS; r++)
      send_item(dir_rows[r].code, dir_rows[r].has, dir_rows[r].last,
                dir_rows[r].known, dir_rows[r].hash);

    // Random strings over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 58; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      target = DIR_ROWS + (ph + 1) * RAND_ITEMS / 4;
      while (items_sent < target) send_string();
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for the hashes still owed after the last item is sent
    waited = 0;
    while (owed_hashes.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (owed_hashes.size() != 0) begin
      $display("%0d hashes never arrived", owed_hashes.size());
      mismatches += owed_hashes.size();
    end

    $display("%0d items in %0d strings sent, %0d hashes checked", items_sent,
             strings_sent, hashes_seen);
    $display("phases: free flow, sender gaps, receiver stalls, both together");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: polynomial_string_hash.f
+incdir+rtl
rtl/psh_pkg.sv
rtl/psh_power.sv
rtl/psh_modmul.sv
rtl/psh_accum.sv
rtl/polynomial_string_hash.sv
tb/tb_top.sv
